// ===== hdl/ftal_pkg.sv =====
// Shared constants and opcodes for the fog table alpha lookup block.
package ftal_pkg;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] REG_HEIGHT_SIZE  = 2'd0;
  localparam logic [1:0] REG_DEPTH_SIZE   = 2'd1;
  localparam logic [1:0] REG_FOG_STRENGTH = 2'd2;

  localparam logic [7:0] HEIGHT_SIZE_RESET  = 8'd1;
  localparam logic [7:0] DEPTH_SIZE_RESET   = 8'd1;
  localparam logic [7:0] FOG_STRENGTH_RESET = 8'd255;

  // 255.499 scaled by 1000
  localparam logic signed [50:0] DEPTH_SCALE = 51'sd255499;
  // one half in Q16, and one half in Q16 times 1000
  localparam logic signed [33:0] HALF_Q16       = 34'sd32768;
  localparam logic signed [50:0] HALF_Q16_X1000 = 51'sd32768000;

  // floor(y / 1000) as (y * RECIP_1000) >> RECIP_SHIFT, exact for y < 2**SF_Y_W
  localparam int SF_Y_W = 26;
  localparam logic [26:0] RECIP_1000 = 27'd68719477;
  localparam int RECIP_SHIFT = 36;

  localparam logic [7:0] FRAC_ONE = 8'd255;

endpackage

// ===== hdl/fog_table_alpha_lookup_top.sv =====
// Fog table alpha lookup: seven-stage pipeline with a dual-read fog table memory.
//
// Input channel (in_valid / in_ready) carries one item per handshake. An item
// with opcode write stores entry_value at entry_index and gives no result.
// An item with opcode lookup samples the height row from coord_height,
// interpolates two depth columns from coord_depth and returns one fog_alpha
// on the output channel (out_valid / out_ready).
// Configuration: cfg_we writes cfg_data to register cfg_index (0 height_size,
// 1 depth_size, 2 fog_strength); other indexes are ignored. Write only while idle.
// Throughput: one item per cycle when out_ready does not hold the pipeline;
// every stage is one pipeline register and the table memory gives two reads
// and one write per cycle.
// Stall: each stage holds while the one after it is full and held, so bubbles
// close up; in_ready drops only when all stages are full and out_ready is low.
// Reset clears the pipeline valid bits and the registers to their defaults;
// the table contents are undefined until written. TABLE_ENTRIES is a power of two.
module fog_table_alpha_lookup_top
  import ftal_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16384,
  parameter int MAX_SIDE      = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                opcode,
  input  logic [13:0]         entry_index,
  input  logic [7:0]          entry_value,
  input  logic signed [23:0]  coord_depth,
  input  logic signed [23:0]  coord_height,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          fog_alpha,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  localparam int ADDR_W = $clog2(TABLE_ENTRIES);
  localparam logic [8:0] SIDE_LIM = 9'(MAX_SIDE);

  // configuration
  logic [7:0] height_size, depth_size, fog_strength;
  logic [7:0] h_eff, l_eff, hm1, lm1;

  always_ff @(posedge clk) begin
    if (rst) begin
      height_size  <= HEIGHT_SIZE_RESET;
      depth_size   <= DEPTH_SIZE_RESET;
      fog_strength <= FOG_STRENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEIGHT_SIZE:  height_size  <= cfg_data;
        REG_DEPTH_SIZE:   depth_size   <= cfg_data;
        REG_FOG_STRENGTH: fog_strength <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (height_size == 8'd0) h_eff = 8'd1;
    else if ({1'b0, height_size} > SIDE_LIM) h_eff = SIDE_LIM[7:0];
    else h_eff = height_size;
    if (depth_size == 8'd0) l_eff = 8'd1;
    else if ({1'b0, depth_size} > SIDE_LIM) l_eff = SIDE_LIM[7:0];
    else l_eff = depth_size;
    hm1 = h_eff - 8'd1;
    lm1 = l_eff - 8'd1;
  end

  // stage valids and enables
  logic v1, v2, v3, v4, v5, v6;
  logic en1, en2, en3, en4, en5, en6, en7;
  logic s4_op;

  assign en7 = !out_valid || out_ready;
  assign en6 = !v6 || en7;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4 && (s4_op == OP_LOOKUP);
      if (en6) v6 <= v5;
      if (en7) out_valid <= v6;
    end
  end

  // stage 1: products of coordinates and sizes
  logic              s1_op;
  logic [13:0]       s1_idx;
  logic [7:0]        s1_val;
  logic signed [32:0] s1_th, s1_sl;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_op  <= opcode;
      s1_idx <= entry_index;
      s1_val <= entry_value;
      s1_th  <= 33'(coord_height) * $signed(33'({1'b0, h_eff}));
      s1_sl  <= 33'(coord_depth) * $signed(33'({1'b0, l_eff}));
    end
  end

  // stage 2: row rounding and clamp, depth scaling
  logic signed [33:0] row_sum;
  logic signed [17:0] row_raw;
  logic [7:0]         row_clamped;
  logic signed [50:0] depth_full;
  logic               s2_op;
  logic [13:0]        s2_idx;
  logic [7:0]         s2_val;
  logic [7:0]         s2_row;
  logic signed [34:0] s2_y;

  always_comb begin
    row_sum = 34'(s1_th) + HALF_Q16;
    row_raw = row_sum[33:16];
    if (row_raw[17]) row_clamped = 8'd0;
    else if (row_raw[16:0] > {9'd0, hm1}) row_clamped = hm1;
    else row_clamped = row_raw[7:0];
    depth_full = 51'(s1_sl) * DEPTH_SCALE + HALF_Q16_X1000;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_op  <= s1_op;
      s2_idx <= s1_idx;
      s2_val <= s1_val;
      s2_row <= row_clamped;
      s2_y   <= depth_full[50:16];
    end
  end

  // stage 3: divide by 1000 through reciprocal, row base address
  logic [52:0] recip_prod;
  logic        s3_op;
  logic [13:0] s3_idx;
  logic [7:0]  s3_val;
  logic        s3_neg, s3_big;
  logic [15:0] s3_sf;
  logic [15:0] s3_row_base;

  assign recip_prod = 53'(s2_y[SF_Y_W-1:0]) * 53'(RECIP_1000);

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_op       <= s2_op;
      s3_idx      <= s2_idx;
      s3_val      <= s2_val;
      s3_neg      <= s2_y[34];
      s3_big      <= !s2_y[34] && ((|s2_y[33:SF_Y_W]) || recip_prod[RECIP_SHIFT+16]);
      s3_sf       <= recip_prod[RECIP_SHIFT+15:RECIP_SHIFT];
      s3_row_base <= 16'(s2_row) * 16'(l_eff);
    end
  end

  // stage 4: column clamps and addresses
  logic [7:0]  base, c1, c2, frac;
  logic [8:0]  base_p1;
  logic [15:0] addr1_full, addr2_full, idx_full;
  logic [ADDR_W-1:0] s4_idx, s4_addr1, s4_addr2;
  logic [7:0]  s4_val, s4_frac;

  always_comb begin
    base    = s3_sf[15:8];
    base_p1 = {1'b0, base} + 9'd1;
    if (s3_neg) begin
      c1 = 8'd0;
      c2 = 8'd0;
      frac = 8'd0;
    end else if (s3_big) begin
      c1 = lm1;
      c2 = lm1;
      frac = 8'd0;
    end else begin
      c1 = (base > lm1) ? lm1 : base;
      c2 = (base_p1 > {1'b0, lm1}) ? lm1 : base_p1[7:0];
      frac = s3_sf[7:0];
    end
    addr1_full = s3_row_base + {8'd0, c1};
    addr2_full = s3_row_base + {8'd0, c2};
    idx_full   = {2'b00, s3_idx};
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_op    <= s3_op;
      s4_idx   <= idx_full[ADDR_W-1:0];
      s4_val   <= s3_val;
      s4_addr1 <= addr1_full[ADDR_W-1:0];
      s4_addr2 <= addr2_full[ADDR_W-1:0];
      s4_frac  <= frac;
    end
  end

  // stage 5: table access
  logic [7:0] fog_table [TABLE_ENTRIES];
  logic [7:0] s5_a1, s5_a2, s5_frac;

  always_ff @(posedge clk) begin
    if (en5) begin
      if (v4 && (s4_op == OP_WRITE)) fog_table[s4_idx] <= s4_val;
      s5_a1   <= fog_table[s4_addr1];
      s5_a2   <= fog_table[s4_addr2];
      s5_frac <= s4_frac;
    end
  end

  // stage 6: interpolation
  logic [15:0] s6_acc;

  always_ff @(posedge clk) begin
    if (en6) begin
      s6_acc <= 16'(s5_a1) * 16'(FRAC_ONE - s5_frac) + 16'(s5_a2) * 16'(s5_frac);
    end
  end

  // stage 7: strength scaling, output register
  logic [23:0] scaled;

  assign scaled = 24'(s6_acc) * 24'(fog_strength);

  always_ff @(posedge clk) begin
    if (en7) begin
      fog_alpha <= scaled[23:16];
    end
  end

endmodule
